@@ hdl/ldcs_pkg.sv @@
// shared types and constants of the led driver command serializer
package ldcs_pkg;

  localparam int CHIP_COUNT = 4;
  localparam int WORD_BITS  = 16;
  localparam int SHIFT_LEN  = CHIP_COUNT * WORD_BITS;
  localparam int CNT_W      = ($clog2(SHIFT_LEN) > 6) ? $clog2(SHIFT_LEN) : 6;

  localparam logic [2:0] KIND_SCAN   = 3'd0;
  localparam logic [2:0] KIND_CFG    = 3'd1;
  localparam logic [2:0] KIND_VSYNC  = 3'd2;
  localparam logic [2:0] KIND_SWAP   = 3'd3;
  localparam logic [2:0] KIND_PREACT = 3'd4;
  localparam logic [2:0] KIND_ON     = 3'd5;
  localparam logic [2:0] KIND_OFF    = 3'd6;

  localparam logic [CNT_W-1:0] PREACT_CLOCKS = CNT_W'(14);
  localparam logic [CNT_W-1:0] ON_CLOCKS     = CNT_W'(12);
  localparam logic [CNT_W-1:0] OFF_CLOCKS    = CNT_W'(13);

  localparam logic [2:0] FLAG_VSYNC = 3'b001;
  localparam logic [2:0] FLAG_BUSY  = 3'b010;
  localparam logic [2:0] FLAG_SWAP  = 3'b100;

  localparam logic [5:0] RGB_RED   = 6'h09;
  localparam logic [5:0] RGB_GREEN = 6'h12;
  localparam logic [5:0] RGB_BLUE  = 6'h24;

  localparam logic [5:0] ROW_LIMIT = 6'd32;

  localparam logic CFG_VSYNC_LATCH = 1'b0;
  localparam logic CFG_SCAN_LINES  = 1'b1;

  typedef struct packed {
    logic [3:0] vsync_latch_clocks;
    logic [5:0] scan_line_count;
  } cfg_t;

  typedef struct packed {
    logic       clock_pulse;
    logic [5:0] rgb;
    logic       latch;
    logic [4:0] row_address;
    logic       pwm_start;
    logic       last;
  } res_t;

endpackage

@@ hdl/ldcs_seq.sv @@
// command sequencer with the shared pulse counter and bit select unit
module ldcs_seq import ldcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_red_word,
  input  logic [15:0] in_green_word,
  input  logic [15:0] in_blue_word,
  input  logic [4:0]  in_latch_bits,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BURST = 4'b0010,
    S_SHIFT = 4'b0100,
    S_CLOSE = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             close_after_r, close_after_nxt;
  logic [4:0]       row_r, row_nxt;
  logic [2:0]       flags_r, flags_nxt;
  logic [5:0]       rgb_hold_r, rgb_hold_nxt;
  logic [15:0]      red_r, green_r, blue_r;
  logic [4:0]       start_r;

  logic             accept;
  logic             fire;
  logic [3:0]       bit_idx;
  logic [3:0]       sel;
  logic             final_chip;
  logic [5:0]       shift_rgb;
  logic             shift_latch;
  logic [1:0]       frames;
  logic [2:0]       scan_flags;
  logic [CNT_W-1:0] burst_len;
  logic [5:0]       row_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r != S_IDLE);
  assign fire      = res_valid && res_ready;

  // bit select for the current shift clock
  assign bit_idx     = cnt_r[3:0];
  assign sel         = 4'd15 - bit_idx;
  assign final_chip  = (cnt_r[CNT_W-1:4] == (CNT_W-4)'(CHIP_COUNT - 1));
  assign shift_rgb   = (red_r[sel]   ? RGB_RED   : 6'd0) |
                       (green_r[sel] ? RGB_GREEN : 6'd0) |
                       (blue_r[sel]  ? RGB_BLUE  : 6'd0);
  assign shift_latch = final_chip && ({1'b0, bit_idx} >= start_r);

  // sync frames on row zero
  always_comb begin
    if ((flags_r & FLAG_VSYNC) != 3'd0) begin
      frames     = 2'd2;
      scan_flags = FLAG_BUSY;
    end else begin
      frames     = (((flags_r & FLAG_BUSY) != 3'd0) ? 2'd0 : 2'd2) +
                   (((flags_r & FLAG_SWAP) != 3'd0) ? 2'd1 : 2'd0);
      scan_flags = flags_r & ~FLAG_SWAP;
    end
    burst_len = CNT_W'(frames) * CNT_W'(cfg.vsync_latch_clocks);
  end

  assign row_inc = {1'b0, row_r} + 6'd1;

  always_comb begin
    res = '0;
    res.row_address = row_r;
    unique case (state_r)
      S_BURST: begin
        res.clock_pulse = 1'b1;
        res.rgb         = rgb_hold_r;
        res.latch       = 1'b1;
        res.last        = !close_after_r && (cnt_r == CNT_W'(1));
      end
      S_SHIFT: begin
        res.clock_pulse = 1'b1;
        res.rgb         = shift_rgb;
        res.latch       = shift_latch;
        res.last        = (cnt_r == CNT_W'(SHIFT_LEN - 1));
      end
      S_CLOSE: begin
        res.rgb       = rgb_hold_r;
        res.pwm_start = 1'b1;
        res.last      = 1'b1;
      end
      default: begin
        res.rgb = rgb_hold_r;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    close_after_nxt = close_after_r;
    row_nxt         = row_r;
    flags_nxt       = flags_r;
    rgb_hold_nxt    = rgb_hold_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_SCAN: begin
              close_after_nxt = 1'b1;
              if (row_r == 5'd0) begin
                flags_nxt = scan_flags;
                if (burst_len != '0) begin
                  state_nxt = S_BURST;
                  cnt_nxt   = burst_len;
                end else begin
                  state_nxt = S_CLOSE;
                end
              end else begin
                state_nxt = S_CLOSE;
              end
            end
            KIND_CFG: begin
              state_nxt = S_SHIFT;
              cnt_nxt   = '0;
            end
            KIND_VSYNC: flags_nxt = FLAG_VSYNC;
            KIND_SWAP:  flags_nxt = FLAG_SWAP;
            KIND_PREACT: begin
              state_nxt       = S_BURST;
              cnt_nxt         = PREACT_CLOCKS;
              close_after_nxt = 1'b0;
            end
            KIND_ON: begin
              state_nxt       = S_BURST;
              cnt_nxt         = ON_CLOCKS;
              close_after_nxt = 1'b0;
            end
            KIND_OFF: begin
              state_nxt       = S_BURST;
              cnt_nxt         = OFF_CLOCKS;
              close_after_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_BURST: begin
        if (fire) begin
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = close_after_r ? S_CLOSE : S_IDLE;
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      S_SHIFT: begin
        if (fire) begin
          rgb_hold_nxt = shift_rgb;
          if (cnt_r == CNT_W'(SHIFT_LEN - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      S_CLOSE: begin
        if (fire) begin
          state_nxt = S_IDLE;
          if (row_inc == cfg.scan_line_count || row_inc >= ROW_LIMIT) begin
            row_nxt = 5'd0;
          end else begin
            row_nxt = row_inc[4:0];
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      close_after_r <= 1'b0;
      row_r         <= 5'd0;
      flags_r       <= 3'd0;
      rgb_hold_r    <= 6'd0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      close_after_r <= close_after_nxt;
      row_r         <= row_nxt;
      flags_r       <= flags_nxt;
      rgb_hold_r    <= rgb_hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind == KIND_CFG) begin
      red_r   <= in_red_word;
      green_r <= in_green_word;
      blue_r  <= in_blue_word;
      start_r <= 5'd16 - ((in_latch_bits > 5'd16) ? 5'd16 : in_latch_bits);
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_burst_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BURST |-> cnt_r != '0) else $error("burst with zero count");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> cnt_r <= CNT_W'(SHIFT_LEN - 1))
    else $error("shift index out of range");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.last |=> in_ready) else $error("not idle after last result");

endmodule

@@ hdl/ldcs_out_reg.sv @@
// output register between the sequencer and the result channel
module ldcs_out_reg import ldcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid,
  output logic       res_ready,
  input  res_t       res,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

endmodule

@@ hdl/led_driver_command_serializer_unit.sv @@
// top level of the led driver command serializer
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    kind, red/green/blue words, latch_bits
// out      output     out_valid / out_ready  clock_pulse, rgb, latch, row_address, pwm_start, last
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one result per cycle while out_ready does not stall; an item gives one to 64 results,
// set by the pulse counter of the sequencer (a config write gives 16 results per chip)
// requests and unknown kinds give no result
// in_ready is low from acceptance until the last result enters the output register
// a stalled out_ready holds the sequencer; cfg is always ready
// synchronous active-low reset: row 0, flags clear, rgb zero, registers 3 and 32
module led_driver_command_serializer_unit import ldcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_red_word,
  input  logic [15:0] in_green_word,
  input  logic [15:0] in_blue_word,
  input  logic [4:0]  in_latch_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_clock_pulse,
  output logic [5:0]  out_rgb,
  output logic        out_latch,
  output logic [4:0]  out_row_address,
  output logic        out_pwm_start,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  cfg_t cfg_r;
  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vsync_latch_clocks <= 4'd3;
      cfg_r.scan_line_count    <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VSYNC_LATCH: cfg_r.vsync_latch_clocks <= cfg_data[3:0];
        CFG_SCAN_LINES:  cfg_r.scan_line_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  ldcs_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_red_word   (in_red_word),
    .in_green_word (in_green_word),
    .in_blue_word  (in_blue_word),
    .in_latch_bits (in_latch_bits),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  ldcs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_clock_pulse = out_res.clock_pulse;
  assign out_rgb         = out_res.rgb;
  assign out_latch       = out_res.latch;
  assign out_row_address = out_res.row_address;
  assign out_pwm_start   = out_res.pwm_start;
  assign out_last        = out_res.last;

endmodule
